[rtl/core/dog_scale_space_extremum_detect_unit_assert.svh]
// Assertion macros shared by the extremum detector RTL.
`ifndef DOG_SCALE_SPACE_EXTREMUM_DETECT_UNIT_ASSERT_SVH
`define DOG_SCALE_SPACE_EXTREMUM_DETECT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dsed_pkg.sv]
// Shared types and constants of the DoG extremum detector.
package dsed_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Register and field widths
  localparam int unsigned THR_BITS      = 15;
  localparam int unsigned FW_BITS       = 11;
  localparam int unsigned FH_BITS       = 13;
  localparam int unsigned BM_BITS       = 7;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 15;
  localparam int unsigned ROW_BITS      = 12;
  localparam int unsigned OUT_COL_BITS  = 10;
  // Column arithmetic width, covers widths up to 8192 plus margin
  localparam int unsigned WIDE_BITS     = 14;

  localparam int unsigned LAYERS   = 3;
  localparam int unsigned WIN_TAPS = 9;

  // Register reset values and limits
  localparam logic [THR_BITS-1:0] THR_RST    = THR_BITS'(128);
  localparam logic [FW_BITS-1:0]  WIDTH_RST  = FW_BITS'(1024);
  localparam logic [FH_BITS-1:0]  HEIGHT_RST = FH_BITS'(768);
  localparam logic [BM_BITS-1:0]  MARGIN_RST = BM_BITS'(5);
  localparam int unsigned         MIN_DIM    = 3;
  localparam logic [FH_BITS-1:0]  HEIGHT_MAX = FH_BITS'(4096);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_MARGIN    = 2'd3
  } cfg_idx_e;

  // Per-layer comparison result
  typedef struct packed {
    logic all_ge;
    logic all_le;
  } lane_flags_t;

  // Center qualifiers handed to the merge stage
  typedef struct packed {
    logic border_ok;
    logic mag_ok;
    logic negative;
  } center_stat_t;

endpackage

[rtl/core/dsed_if.sv]
// Valid/ready channel interfaces for sample items and result items.
interface dsed_in_if import dsed_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_below;
  logic signed [SampleBits-1:0] sample_middle;
  logic signed [SampleBits-1:0] sample_above;
  logic                         frame_start;

  modport source (output valid, sample_below, sample_middle, sample_above, frame_start,
                  input ready);
  modport sink   (input valid, sample_below, sample_middle, sample_above, frame_start,
                  output ready);
endinterface

interface dsed_out_if import dsed_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [ROW_BITS-1:0]          center_row;
  logic [OUT_COL_BITS-1:0]      center_col;
  logic                         is_extremum;
  logic                         is_maximum;
  logic signed [SampleBits-1:0] center_level;

  modport source (output valid, center_row, center_col, is_extremum, is_maximum,
                  center_level, input ready);
  modport sink   (input valid, center_row, center_col, is_extremum, is_maximum,
                  center_level, output ready);
endinterface

[rtl/core/dsed_line_buf.sv]
// Two-row line store for the three layers, one memory per row parity.
module dsed_line_buf import dsed_pkg::*; #(
  parameter int unsigned MaxWidth   = MAX_WIDTH_DEF,
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF,
  localparam int unsigned ColW      = $clog2(MaxWidth),
  localparam int unsigned LineW     = LAYERS * SampleBits
) (
  input  logic             clk_i,
  input  logic             en_i,     // item accepted: read both rows, write one
  input  logic             sel_i,    // row parity of the row being written
  input  logic [ColW-1:0]  addr_i,
  input  logic [LineW-1:0] wdata_i,
  output logic [LineW-1:0] older_o,  // row - 2
  output logic [LineW-1:0] newer_o   // row - 1
);

  logic [LineW-1:0] mem0_q [MaxWidth];
  logic [LineW-1:0] mem1_q [MaxWidth];
  logic [LineW-1:0] rd0_q;
  logic [LineW-1:0] rd1_q;
  logic             sel_q;

  // read-before-write: the written row hands out its old contents (row - 2)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= mem0_q[addr_i];
      sel_q <= sel_i;
      if (!sel_i) begin
        mem0_q[addr_i] <= wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd1_q <= mem1_q[addr_i];
      if (sel_i) begin
        mem1_q[addr_i] <= wdata_i;
      end
    end
  end

  assign older_o = sel_q ? rd1_q : rd0_q;
  assign newer_o = sel_q ? rd0_q : rd1_q;

endmodule

[rtl/core/dsed_lane.sv]
// One layer lane: compares the center against the taps of its layer.
module dsed_lane import dsed_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF,
  parameter bit          SkipCenter = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [SampleBits-1:0] center_i,
  input  logic signed [SampleBits-1:0] nbr_i [WIN_TAPS],
  output lane_flags_t                  flags_o
);

  lane_flags_t flags_d;
  lane_flags_t flags_q;

  always_comb begin
    flags_d.all_ge = 1'b1;
    flags_d.all_le = 1'b1;
    for (int k = 0; k < WIN_TAPS; k++) begin
      // middle layer: tap 4 is the center itself
      if (!(SkipCenter && (k == WIN_TAPS / 2))) begin
        if (center_i < nbr_i[k]) flags_d.all_ge = 1'b0;
        if (center_i > nbr_i[k]) flags_d.all_le = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

[rtl/core/dsed_merge.sv]
// Merges the three lane results with the center qualifiers.
module dsed_merge import dsed_pkg::*; (
  input  lane_flags_t  flags_i [LAYERS],
  input  center_stat_t stat_i,
  output logic         is_extremum_o,
  output logic         is_maximum_o
);

  logic ge_all;
  logic le_all;

  always_comb begin
    ge_all = 1'b1;
    le_all = 1'b1;
    for (int l = 0; l < LAYERS; l++) begin
      ge_all = ge_all & flags_i[l].all_ge;
      le_all = le_all & flags_i[l].all_le;
    end
    // mag_ok implies a nonzero center, so the sign bit picks max or min
    is_extremum_o = stat_i.border_ok && stat_i.mag_ok &&
                    (stat_i.negative ? le_all : ge_all);
    is_maximum_o  = is_extremum_o && !stat_i.negative;
  end

endmodule

[rtl/core/dog_scale_space_extremum_detect_unit.sv]
// Top level of the 3x3x3 DoG scale-space extremum detector.
//
//  channel  dir  protocol      payload
//  in_i     in   valid/ready   sample_below, sample_middle, sample_above, frame_start
//  out_o    out  valid/ready   center_row, center_col, is_extremum, is_maximum,
//                              center_level
//  cfg_*    in   write only    cfg_idx_i selects register, cfg_wdata_i data
//
// One item per cycle while the output is not held; a result passes through the
// line store read, window shift, lane compare and merge into the output register.
// Pixels of rows 0/1 and columns 0/1 give no result and pass as bubbles.
// Reset clears counters, valid bits and window, loads register reset values;
// the line store is not cleared. A held output stalls the pipeline and drops ready.
`include "dog_scale_space_extremum_detect_unit_assert.svh"

module dog_scale_space_extremum_detect_unit import dsed_pkg::*; #(
  parameter int unsigned MaxWidth   = MAX_WIDTH_DEF,
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  dsed_in_if.sink                  in_i,
  dsed_out_if.source               out_o
);

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned LineW = LAYERS * SampleBits;
  localparam int unsigned MagW  = ((SampleBits > THR_BITS) ? SampleBits : THR_BITS) + 1;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [THR_BITS-1:0] cfg_thr_q;
  logic [FW_BITS-1:0]  cfg_width_q;
  logic [FH_BITS-1:0]  cfg_height_q;
  logic [BM_BITS-1:0]  cfg_margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q    <= THR_RST;
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_margin_q <= MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_THRESHOLD: cfg_thr_q    <= cfg_wdata_i[THR_BITS-1:0];
        REG_WIDTH:     cfg_width_q  <= cfg_wdata_i[FW_BITS-1:0];
        REG_HEIGHT:    cfg_height_q <= cfg_wdata_i[FH_BITS-1:0];
        REG_MARGIN:    cfg_margin_q <= cfg_wdata_i[BM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Flow control: every stage moves together when the output can move
  // ------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic accept;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  // ------------------------------------------------------------------
  // Stage 0: position counters, border test, line store access
  // ------------------------------------------------------------------
  logic [ColW-1:0]      col_q, col_d, col_cur;
  logic [ROW_BITS-1:0]  row_q, row_d, row_cur;
  logic [WIDE_BITS-1:0] eff_w, col_inc, cc;
  logic [FH_BITS-1:0]   eff_h, row_inc, cr_ext;
  logic [BM_BITS-1:0]   margin;
  logic [ROW_BITS-1:0]  cr;
  logic                 emit, border_ok;

  always_comb begin
    // clamp the frame geometry into its legal range
    eff_w = WIDE_BITS'(cfg_width_q);
    if (eff_w < WIDE_BITS'(MIN_DIM)) eff_w = WIDE_BITS'(MIN_DIM);
    if (eff_w > WIDE_BITS'(MaxWidth)) eff_w = WIDE_BITS'(MaxWidth);
    eff_h = cfg_height_q;
    if (eff_h < FH_BITS'(MIN_DIM)) eff_h = FH_BITS'(MIN_DIM);
    if (eff_h > HEIGHT_MAX) eff_h = HEIGHT_MAX;
    margin = (cfg_margin_q == '0) ? BM_BITS'(1) : cfg_margin_q;

    row_cur = in_i.frame_start ? '0 : row_q;
    col_cur = in_i.frame_start ? '0 : col_q;

    col_inc = WIDE_BITS'(col_cur) + WIDE_BITS'(1);
    row_inc = FH_BITS'(row_cur) + FH_BITS'(1);
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = (row_inc >= eff_h) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_cur;
    end

    // center sits one row up and one column left of the incoming pixel
    emit   = (row_cur >= ROW_BITS'(2)) && (col_cur >= ColW'(2));
    cr     = row_cur - ROW_BITS'(1);
    cc     = WIDE_BITS'(col_cur) - WIDE_BITS'(1);
    cr_ext = FH_BITS'(cr);
    border_ok = (cr_ext >= FH_BITS'(margin)) && ((cr_ext + FH_BITS'(margin)) < eff_h) &&
                (cc >= WIDE_BITS'(margin)) && ((cc + WIDE_BITS'(margin)) < eff_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [LineW-1:0] px_line;
  logic [LineW-1:0] older_line;
  logic [LineW-1:0] newer_line;

  assign px_line = {in_i.sample_above, in_i.sample_middle, in_i.sample_below};

  dsed_line_buf #(
    .MaxWidth   (MaxWidth),
    .SampleBits (SampleBits)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .sel_i   (row_cur[0]),
    .addr_i  (col_cur),
    .wdata_i (px_line),
    .older_o (older_line),
    .newer_o (newer_line)
  );

  // ------------------------------------------------------------------
  // Stage 1: line store data ready, item payload registered
  // ------------------------------------------------------------------
  logic                         s1_valid_q;
  logic                         s1_emit_q;
  logic                         s1_border_q;
  logic [ROW_BITS-1:0]          s1_row_q;
  logic [OUT_COL_BITS-1:0]      s1_col_q;
  logic [LineW-1:0]             s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q   <= emit;
      s1_border_q <= border_ok;
      s1_row_q    <= cr;
      s1_col_q    <= cc[OUT_COL_BITS-1:0];
      s1_px_q     <= px_line;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: 3x3x3 window, [layer][row][col], col 2 newest
  // ------------------------------------------------------------------
  logic signed [SampleBits-1:0] win_q [LAYERS][3][3];
  logic                         s2_valid_q;
  logic                         s2_border_q;
  logic [ROW_BITS-1:0]          s2_row_q;
  logic [OUT_COL_BITS-1:0]      s2_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int l = 0; l < LAYERS; l++) begin
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) begin
            win_q[l][r][k] <= '0;
          end
        end
      end
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      if (s1_valid_q) begin
        for (int l = 0; l < LAYERS; l++) begin
          for (int r = 0; r < 3; r++) begin
            win_q[l][r][0] <= win_q[l][r][1];
            win_q[l][r][1] <= win_q[l][r][2];
          end
          win_q[l][0][2] <= older_line[l*SampleBits +: SampleBits];
          win_q[l][1][2] <= newer_line[l*SampleBits +: SampleBits];
          win_q[l][2][2] <= s1_px_q[l*SampleBits +: SampleBits];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_border_q <= s1_border_q;
      s2_row_q    <= s1_row_q;
      s2_col_q    <= s1_col_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: per-layer lanes compare in parallel, center qualifiers
  // ------------------------------------------------------------------
  logic signed [SampleBits-1:0] center;
  logic signed [SampleBits-1:0] lane_nbr [LAYERS][WIN_TAPS];
  lane_flags_t                  lane_flags [LAYERS];
  logic signed [MagW-1:0]       center_ext;
  logic [MagW-1:0]              mag;
  center_stat_t                 stat_d;

  assign center = win_q[1][1][1];

  always_comb begin
    for (int l = 0; l < LAYERS; l++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          lane_nbr[l][r*3 + k] = win_q[l][r][k];
        end
      end
    end
  end

  for (genvar l = 0; l < LAYERS; l++) begin : g_lane
    dsed_lane #(
      .SampleBits (SampleBits),
      .SkipCenter (1'(l == 1))
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .center_i (center),
      .nbr_i    (lane_nbr[l]),
      .flags_o  (lane_flags[l])
    );
  end

  always_comb begin
    center_ext       = MagW'(center);
    mag              = center_ext[MagW-1] ? -center_ext : center_ext;
    // a magnitude above a nonnegative threshold also rules out a zero center
    stat_d.mag_ok    = mag > MagW'(cfg_thr_q);
    stat_d.negative  = center[SampleBits-1];
    stat_d.border_ok = s2_border_q;
  end

  logic                         s3_valid_q;
  center_stat_t                 s3_stat_q;
  logic [ROW_BITS-1:0]          s3_row_q;
  logic [OUT_COL_BITS-1:0]      s3_col_q;
  logic signed [SampleBits-1:0] s3_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_stat_q  <= stat_d;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_level_q <= center;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: merge lanes into the output register
  // ------------------------------------------------------------------
  logic                         is_ext_d, is_max_d;
  logic [ROW_BITS-1:0]          out_row_q;
  logic [OUT_COL_BITS-1:0]      out_col_q;
  logic                         out_ext_q, out_max_q;
  logic signed [SampleBits-1:0] out_level_q;

  dsed_merge u_merge (
    .flags_i       (lane_flags),
    .stat_i        (s3_stat_q),
    .is_extremum_o (is_ext_d),
    .is_maximum_o  (is_max_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_q   <= s3_row_q;
      out_col_q   <= s3_col_q;
      out_ext_q   <= is_ext_d;
      out_max_q   <= is_max_d;
      out_level_q <= s3_level_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.center_row   = out_row_q;
  assign out_o.center_col   = out_col_q;
  assign out_o.is_extremum  = out_ext_q;
  assign out_o.is_maximum   = out_max_q;
  assign out_o.center_level = out_level_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `DSED_ASSERT_IMP(a_max_is_ext, out_valid_q && out_max_q, out_ext_q,
                   "maximum flagged without extremum")
  `DSED_ASSERT_IMP(a_ext_nonzero, out_valid_q && out_ext_q, out_level_q != '0,
                   "extremum flagged on zero center")
  `DSED_ASSERT_IMP(a_row_nonzero, out_valid_q, out_row_q != '0,
                   "result for center in row 0")
  `DSED_ASSERT_IMP(a_col_range, 1'b1, 32'(col_q) < MaxWidth,
                   "column counter beyond line store depth")
  `DSED_ASSERT_NXT(a_accept_s1, accept, s1_valid_q,
                   "accepted item missing from stage 1")

endmodule

[verif/dog_scale_space_extremum_detect_unit_checker.sv]
// Watches the sample and result channels, predicts each center result and compares it.
module dog_scale_space_extremum_detect_unit_checker import dsed_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  dsed_in_if                       pix_i,
  dsed_out_if                      res_i,
  output int unsigned              fail_count_o,
  output int unsigned              centers_due_o
);

  localparam int unsigned MaxW      = MAX_WIDTH_DEF;
  localparam int unsigned MaxPrints = 50;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct {
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    ext;
    logic                    is_max;
    sample_t                 level;
  } center_t;

  // two previous rows per layer, indexed by row parity
  sample_t rows_q [2][MaxW][LAYERS];
  // [layer][row][col], index 0 oldest
  sample_t win_q [LAYERS][3][3];
  int unsigned col_q;
  int unsigned row_q;

  logic [THR_BITS-1:0] thr_q;
  logic [FW_BITS-1:0]  width_q;
  logic [FH_BITS-1:0]  height_q;
  logic [BM_BITS-1:0]  margin_q;

  center_t centers_due [$];

  task automatic report_mismatch(string what);
    // keep the log short on a badly broken block; every mismatch still counts
    if (fail_count_o < MaxPrints) $display("MISMATCH %s", what);
    fail_count_o++;
  endtask

  function automatic bit center_qualifies(sample_t c, output bit is_max);
    int mag;
    mag = (c < 0) ? -int'(c) : int'(c);
    is_max = 1'b0;
    if (mag <= int'(thr_q) || c == 0) return 1'b0;
    for (int l = 0; l < LAYERS; l++)
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) begin
          if (l == 1 && r == 1 && k == 1) continue;
          if (c > 0 && c < win_q[l][r][k]) return 1'b0;
          if (c < 0 && c > win_q[l][r][k]) return 1'b0;
        end
    is_max = (c > 0);
    return 1'b1;
  endfunction

  task automatic take_pixel(sample_t b, sample_t m, sample_t a, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned mg;
    int unsigned row;
    int unsigned col;
    int unsigned cb;
    int unsigned pb;
    int unsigned cr;
    int unsigned cc;
    sample_t     px [LAYERS];
    center_t     due;
    bit          mx;
    bit          ext;
    w  = (width_q < MIN_DIM) ? MIN_DIM : ((width_q > MaxW) ? MaxW : int'(width_q));
    h  = (height_q < MIN_DIM) ? MIN_DIM :
         ((height_q > HEIGHT_MAX) ? int'(HEIGHT_MAX) : int'(height_q));
    mg = (margin_q < 1) ? 1 : int'(margin_q);
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    row   = row_q;
    col   = col_q % MaxW;
    px[0] = b;
    px[1] = m;
    px[2] = a;
    cb    = row & 1;
    pb    = cb ^ 1;
    for (int l = 0; l < LAYERS; l++) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 2; k++) win_q[l][r][k] = win_q[l][r][k+1];
      win_q[l][0][2]      = rows_q[cb][col][l];
      win_q[l][1][2]      = rows_q[pb][col][l];
      win_q[l][2][2]      = px[l];
      rows_q[cb][col][l]  = px[l];
    end
    if (row >= 2 && col >= 2) begin
      cr  = row - 1;
      cc  = col - 1;
      mx  = 1'b0;
      ext = 1'b0;
      if (cr >= mg && cr + mg < h && cc >= mg && cc + mg < w)
        ext = center_qualifies(win_q[1][1][1], mx);
      due.row    = ROW_BITS'(cr);
      due.col    = OUT_COL_BITS'(cc);
      due.ext    = ext;
      due.is_max = mx;
      due.level  = win_q[1][1][1];
      centers_due = {centers_due, due};
    end
    if (col + 1 >= w) begin
      col_q = 0;
      row_q = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_q = col + 1;
    end
  endtask

  task automatic check_result();
    center_t due;
    if (centers_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: row %0d col %0d",
                                res_i.center_row, res_i.center_col));
      return;
    end
    due = centers_due.pop_front();
    if (res_i.center_row !== due.row || res_i.center_col !== due.col ||
        res_i.is_extremum !== due.ext || res_i.is_maximum !== due.is_max ||
        res_i.center_level !== due.level)
      report_mismatch($sformatf(
        "center (%0d,%0d) ext %0b max %0b level %0d, due (%0d,%0d) ext %0b max %0b level %0d",
        res_i.center_row, res_i.center_col, res_i.is_extremum, res_i.is_maximum,
        res_i.center_level, due.row, due.col, due.ext, due.is_max, due.level));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    = THR_RST;
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      margin_q = MARGIN_RST;
      col_q    = 0;
      row_q    = 0;
      for (int l = 0; l < LAYERS; l++)
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++) win_q[l][r][k] = '0;
      centers_due.delete();
      fail_count_o  = 0;
      centers_due_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_THRESHOLD: thr_q    = THR_BITS'(cfg_wdata_i);
          REG_WIDTH:     width_q  = cfg_wdata_i[FW_BITS-1:0];
          REG_HEIGHT:    height_q = cfg_wdata_i[FH_BITS-1:0];
          REG_MARGIN:    margin_q = cfg_wdata_i[BM_BITS-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) check_result();
      if (pix_i.valid && pix_i.ready)
        take_pixel(pix_i.sample_below, pix_i.sample_middle, pix_i.sample_above,
                   pix_i.frame_start);
      centers_due_o = centers_due.size();
    end
  end

endmodule

[verif/dog_scale_space_extremum_detect_unit_tb.sv]
// Stimulus and verdict for the DoG 3x3x3 extremum detector.
module dog_scale_space_extremum_detect_unit_tb;
  import dsed_pkg::*;

  // Cycles to let the pipeline empty once nothing is due.
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandPhases  = 12;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  // sample textures: small noise with spikes, flat plateau with dips, raw words
  typedef enum int unsigned {
    TEX_NOISE,
    TEX_PLATEAU,
    TEX_RAW
  } texture_e;

  // Middle layer of the opening 5x5 frame, row-major: a full-scale peak, a
  // zero center, a full-scale pit and two tied minima of -7.
  localparam sample_t MidPattern [25] = '{
    16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,  16'sh0000,
    16'sh0000, 16'sh7FFF, 16'sh0003, -16'sh0007, 16'sh0000,
    16'sh0000, 16'sh0003, 16'sh0000, -16'sh0007, 16'sh0000,
    16'sh0000, -16'sh0007, -16'sh0007, 16'sh8000, 16'sh0000,
    16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,  16'sh0000
  };

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_idx_e                 cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  bit                       steady;      // no idling on either side while set
  int unsigned              fail_count;
  int unsigned              centers_due;

  dsed_in_if  pix_ch ();
  dsed_out_if res_ch ();

  dog_scale_space_extremum_detect_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pix_ch),
    .out_o       (res_ch)
  );

  dog_scale_space_extremum_detect_unit_checker u_extremum_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .pix_i         (pix_ch),
    .res_i         (res_ch),
    .fail_count_o  (fail_count),
    .centers_due_o (centers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("dog_scale_space_extremum_detect_unit verification failed");
    $finish;
  end

  // Result side: back-pressure about 16 percent of the time, none while steady.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= 16);
    end
  end

  // Drive one item from a falling edge and hold it until accepted. Returns at
  // the falling edge after the handshake with valid still high, so the next
  // call either replaces the payload or drops valid, never both.
  task automatic send_pixel(sample_t b, sample_t m, sample_t a, logic fs);
    while (!steady && $urandom_range(99) < 16) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid         <= 1'b1;
    pix_ch.sample_below  <= b;
    pix_ch.sample_middle <= m;
    pix_ch.sample_above  <= a;
    pix_ch.frame_start   <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait for every due center, then let bubbles flush:
  // pixels of the first rows and columns leave no result behind.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (centers_due != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Registers are only touched with the pipeline empty.
  task automatic configure(int unsigned thr, int unsigned w, int unsigned h,
                           int unsigned mg);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_THRESHOLD;
    cfg_wdata <= CFG_DATA_BITS'(thr);
    @(negedge clk);
    cfg_idx   <= REG_WIDTH;
    cfg_wdata <= CFG_DATA_BITS'(w);
    @(negedge clk);
    cfg_idx   <= REG_HEIGHT;
    cfg_wdata <= CFG_DATA_BITS'(h);
    @(negedge clk);
    cfg_idx   <= REG_MARGIN;
    cfg_wdata <= CFG_DATA_BITS'(mg);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic sample_t pick_sample(texture_e tex, sample_t level);
    int unsigned dice;
    sample_t     mag;
    dice = $urandom_range(99);
    case (tex)
      TEX_NOISE: begin
        if (dice < 8) begin
          // isolated spikes are what turn into extrema
          mag = sample_t'($urandom_range(32767, 150));
          return $urandom_range(1) ? mag : -mag;
        end
        if (dice < 14) return sample_t'($urandom);
        return sample_t'(int'($urandom_range(200)) - 100);
      end
      TEX_PLATEAU: begin
        // flat areas make most interior centers tie with their neighbors
        if (dice < 6) return level + sample_t'(int'($urandom_range(6)) - 3);
        return level;
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Raster stream of frames; the first item opens a frame when fresh is set,
  // later items restart the frame now and then (restart_pct of 100).
  task automatic run_frames(int unsigned count, texture_e tex, bit fresh,
                            int unsigned restart_pct);
    sample_t level;
    level = sample_t'($urandom_range(30000));
    if ($urandom_range(1)) level = -level;
    for (int unsigned i = 0; i < count; i++)
      send_pixel(pick_sample(tex, level), pick_sample(tex, level), pick_sample(tex, level),
                 (fresh && i == 0) || ($urandom_range(99) < restart_pct));
  endtask

  initial begin
    int unsigned thr;
    int unsigned w;
    int unsigned h;
    int unsigned mg;
    int unsigned n;
    int unsigned dice;
    texture_e    tex;
    sample_t     below;
    sample_t     above;

    rst_n                = 1'b0;
    steady               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_THRESHOLD;
    cfg_wdata            = '0;
    pix_ch.valid         = 1'b0;
    pix_ch.sample_below  = '0;
    pix_ch.sample_middle = '0;
    pix_ch.sample_above  = '0;
    pix_ch.frame_start   = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed 5x5 frame, zero threshold, smallest margin: peak and pit at
    // full scale, ties with the outer layers, a zero center, tied minima.
    // The frame height is reached exactly, so the row count wraps after it.
    configure(0, 5, 5, 1);
    for (int i = 0; i < 25; i++) begin
      below = (i == 6) ? 16'sh7FFF : ((i == 18) ? 16'sh8000 : 16'sh0000);
      above = (i == 0) ? -16'sh0001 : ((i == 6) ? 16'sh7FFF : 16'sh0000);
      send_pixel(below, MidPattern[i], above, i == 0);
    end

    // Random frames of small size; register values include the clamped
    // ranges (width and height below three or above the maximum, margin
    // zero) and the largest threshold and margin. One phase runs with
    // neither side idling.
    for (int unsigned p = 0; p < RandPhases; p++) begin
      dice = $urandom_range(99);
      thr  = (dice < 15) ? 0 : ((dice < 25) ? (1 << CFG_DATA_BITS) - 1 : $urandom_range(300));
      dice = $urandom_range(19);
      w    = (dice == 0) ? $urandom_range(2) : ((dice == 1) ? 2047 : $urandom_range(12, 3));
      dice = $urandom_range(19);
      h    = (dice == 0) ? $urandom_range(2) : ((dice == 1) ? 8191 : $urandom_range(10, 3));
      dice = $urandom_range(9);
      mg   = (dice == 0) ? 0 : ((dice == 1) ? 127 : $urandom_range(3, 1));
      dice = $urandom_range(9);
      tex  = (dice < 6) ? TEX_NOISE : ((dice < 8) ? TEX_PLATEAU : TEX_RAW);
      n    = $urandom_range(100, 70);
      configure(thr, w, h, mg);
      steady = (p == 2);
      run_frames(n / 2, tex, 1'b1, 2);
      // once, hold the sender mid-frame until every due center has come out
      if (p == RandPhases / 2) drain_results();
      run_frames(n - n / 2, tex, 1'b0, 2);
    end
    steady = 1'b0;

    drain_results();
    if (fail_count == 0) begin
      $display("dog_scale_space_extremum_detect_unit verification clean");
    end else begin
      $display("dog_scale_space_extremum_detect_unit verification failed");
    end
    $finish;
  end

endmodule
